/* hw/rtl/srtf_pkg.sv */
package srtf_pkg;

  // Fixed field widths of the item and result.
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned CLOCK_W = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned TOTAL_W = 40;

  // Default number of job slots.
  localparam int unsigned SLOTS_DEFAULT = 16;

  // Item operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Saturation limits.
  localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // One job slot as held in the table memory.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } entry_t;

endpackage

/* hw/rtl/srtf_table.sv */
module srtf_table import srtf_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t           mem_q [SLOTS];
  entry_t           rd_raw_q;
  logic [SLOTS-1:0] vld_q;
  logic             rd_vld_q;

  // Synchronous single-port write, single-port read whose data is registered and appears in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem_q[rd_addr_i];
    end
  end

  // Per-slot valid bits so that a slot never written reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

/* hw/rtl/srtf_pick.sv */
module srtf_pick import srtf_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               cmp_vld_i,
  input  logic [IDX_W-1:0]   cmp_idx_i,
  input  entry_t             cmp_entry_i,
  input  logic [CLOCK_W-1:0] clock_i,
  output logic               found_o,
  output logic [IDX_W-1:0]   best_idx_o,
  output entry_t             best_o
);

  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  entry_t           best_q;
  logic             arrived;
  logic             better;

  // A slot qualifies when its job has arrived and still needs service; the
  // strict compare keeps the lowest slot on a tie.
  assign arrived = {{(CLOCK_W-TIME_W){1'b0}}, cmp_entry_i.arrival} <= clock_i;
  assign better  = arrived && (cmp_entry_i.remaining != '0) &&
                   (!found_q || (cmp_entry_i.remaining < best_q.remaining));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (start_i) begin
      found_q <= 1'b0;
    end else if (cmp_vld_i && better) begin
      found_q <= 1'b1;
    end
  end

  // Running best candidate.
  always_ff @(posedge clk_i) begin
    if (cmp_vld_i && better) begin
      best_idx_q <= cmp_idx_i;
      best_q     <= cmp_entry_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_o     = best_q;

endmodule

/* hw/rtl/shortest_remaining_time_scheduler.sv */
// Preemptive shortest-remaining-time-first scheduler over SLOTS job slots held
// in a synchronous table memory. An add item writes its slot if the slot is in
// range and gives no result. A tick item reads the table one slot per cycle,
// keeping the arrived job with the least nonzero remaining time (lowest slot on
// a tie), then writes back the decremented entry and computes completion
// statistics; the scan is paced by the single read port of the table. The next
// item is taken while a result waits in the output register. Time, the
// completion count and totals saturate.
module shortest_remaining_time_scheduler import srtf_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [TIME_W-1:0]  arrival_i,
  input  logic [TIME_W-1:0]  burst_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ran_o,
  output logic [SLOT_W-1:0]  ran_slot_o,
  output logic               finished_o,
  output logic [CLOCK_W-1:0] done_time_o,
  output logic [CLOCK_W-1:0] turnaround_o,
  output logic [CLOCK_W-1:0] waiting_o,
  output logic [COUNT_W-1:0] jobs_done_o,
  output logic [TOTAL_W-1:0] sum_waiting_o,
  output logic [TOTAL_W-1:0] sum_turnaround_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > SLOT_W + 1) ? IDX_W + 1 : SLOT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   scan_q;
  logic               rd_pend_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [CLOCK_W-1:0] clock_q;
  logic [COUNT_W-1:0] count_q;
  logic [TOTAL_W-1:0] wait_tot_q;
  logic [TOTAL_W-1:0] tat_tot_q;
  logic               fin_q;
  logic [CLOCK_W-1:0] tat_q;
  logic               out_vld_q;
  logic               ran_q;
  logic [SLOT_W-1:0]  ran_slot_q;
  logic               finished_q;
  logic [CLOCK_W-1:0] done_time_q;
  logic [CLOCK_W-1:0] tat_out_q;
  logic [CLOCK_W-1:0] wait_out_q;

  logic               in_acc;
  logic               add_acc;
  logic               tick_acc;
  logic               in_range;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  entry_t             rd_data;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  entry_t             best;
  logic [CLOCK_W-1:0] clock_next;
  logic [TIME_W-1:0]  rem_next;
  logic               fin_next;
  logic               out_free;
  logic [CLOCK_W-1:0] burst_ext;
  logic [CLOCK_W-1:0] wait_val;
  logic [TOTAL_W:0]   wait_sum;
  logic [TOTAL_W:0]   tat_sum;

  // Input handshake: items are taken only between ticks.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign add_acc    = in_acc && (op_i == OP_ADD);
  assign tick_acc   = in_acc && (op_i == OP_TICK);
  assign in_range   = CMP_W'(slot_i) < CMP_W'(SLOTS);
  assign out_free   = !out_vld_q || !out_stall_i;

  // Table write port: an add writes its slot if in range, a tick writes back its pick.
  assign rem_next = best.remaining - TIME_W'(1);
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = best;
    if (add_acc) begin
      wr_en             = in_range;
      wr_addr           = IDX_W'(slot_i);
      wr_data.arrival   = arrival_i;
      wr_data.burst     = burst_i;
      wr_data.remaining = burst_i;
    end else if (state_q == S_FIN) begin
      wr_en             = found;
      wr_data.remaining = rem_next;
    end
  end

  assign rd_en = (state_q == S_SCAN);

  srtf_table #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q),
    .rd_data_o (rd_data)
  );

  srtf_pick #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (tick_acc),
    .cmp_vld_i   (rd_pend_q),
    .cmp_idx_i   (rd_idx_q),
    .cmp_entry_i (rd_data),
    .clock_i     (clock_q),
    .found_o     (found),
    .best_idx_o  (best_idx),
    .best_o      (best)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (tick_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_FIN;
      S_FIN:   state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Tick arithmetic.
  assign clock_next = (clock_q == CLOCK_MAX) ? clock_q : clock_q + CLOCK_W'(1);
  assign fin_next   = found && (rem_next == '0);
  assign burst_ext  = {{(CLOCK_W-TIME_W){1'b0}}, best.burst};
  assign wait_val   = (fin_q && (tat_q >= burst_ext)) ? tat_q - burst_ext : '0;
  assign wait_sum   = {1'b0, wait_tot_q} + (TOTAL_W+1)'(wait_val);
  assign tat_sum    = {1'b0, tat_tot_q} + (TOTAL_W+1)'(tat_q);

  // Control state, clock and running statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_q     <= '0;
      rd_pend_q  <= 1'b0;
      rd_idx_q   <= '0;
      clock_q    <= '0;
      count_q    <= '0;
      wait_tot_q <= '0;
      tat_tot_q  <= '0;
      fin_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en;
      rd_idx_q  <= scan_q;
      if (tick_acc) begin
        scan_q <= '0;
      end else if (rd_en && (scan_q != LAST_IDX)) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (state_q == S_FIN) begin
        clock_q <= clock_next;
        fin_q   <= fin_next;
      end
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if ((state_q == S_EMIT) && out_free) begin
        out_vld_q <= 1'b1;
        if (fin_q) begin
          if (count_q != COUNT_MAX) begin
            count_q <= count_q + COUNT_W'(1);
          end
          wait_tot_q <= wait_sum[TOTAL_W] ? TOTAL_MAX : wait_sum[TOTAL_W-1:0];
          tat_tot_q  <= tat_sum[TOTAL_W] ? TOTAL_MAX : tat_sum[TOTAL_W-1:0];
        end
      end
    end
  end

  // Turnaround of a finishing job, and the result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      tat_q <= fin_next ? clock_next - {{(CLOCK_W-TIME_W){1'b0}}, best.arrival} : '0;
    end
    if ((state_q == S_EMIT) && out_free) begin
      ran_q       <= found;
      ran_slot_q  <= found ? SLOT_W'(best_idx) : '0;
      finished_q  <= fin_q;
      done_time_q <= clock_q;
      tat_out_q   <= tat_q;
      wait_out_q  <= wait_val;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign ran_o            = ran_q;
  assign ran_slot_o       = ran_slot_q;
  assign finished_o       = finished_q;
  assign done_time_o      = done_time_q;
  assign turnaround_o     = tat_out_q;
  assign waiting_o        = wait_out_q;
  assign jobs_done_o      = count_q;
  assign sum_waiting_o    = wait_tot_q;
  assign sum_turnaround_o = tat_tot_q;

  // A result appears only from the emit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside the emit step");

  // A picked job always still needs service when it is written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && found) |-> (best.remaining != '0))
    else $error("picked slot has no remaining time");

  // The scheduler clock never runs backwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (clock_q >= $past(clock_q)))
    else $error("clock decreased");

  // A finished tick always reports a job that ran.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && finished_q) |-> ran_q)
    else $error("finished without a running job");

endmodule
